### rtl/core/agfe_pkg.sv
// Shared types, constants and helper functions for the audio gain, fade and echo effect.
// Used by agfe_ramp_div and the top level; depends on nothing else.
package agfe_pkg;

    localparam int SAMPLE_W  = 16;
    localparam int INDEX_W   = 25;
    localparam int MAX_DELAY = 8192;
    localparam int DELAY_AW  = $clog2(MAX_DELAY);
    localparam int FILL_W    = DELAY_AW + 1;
    localparam int CLIP_W    = 24;
    localparam int PLEN_W    = CLIP_W + 1;
    localparam int GAIN_W    = 15;
    localparam int MODE_W    = 3;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_W     = 24;
    localparam int MAG_W     = SAMPLE_W + 1;
    localparam int QUOT_W    = SAMPLE_W + 1;
    localparam int PROD_W    = MAG_W + PLEN_W;
    localparam int STEP_W    = $clog2(QUOT_W + 1);
    localparam int WIDE_W    = SAMPLE_W + 3;

    // Register indexes on the configuration port.
    localparam logic [CFG_IDX_W-1:0] REG_EFFECT_MODE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FADE_OUT_EN = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CLIP_LENGTH = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ECHO_DELAY  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_ECHO_GAIN   = 3'd4;

    // Effect codes.
    localparam logic [MODE_W-1:0] MODE_NONE     = 3'd0;
    localparam logic [MODE_W-1:0] MODE_FADE_IN  = 3'd1;
    localparam logic [MODE_W-1:0] MODE_HALF     = 3'd2;
    localparam logic [MODE_W-1:0] MODE_BOOST    = 3'd3;
    localparam logic [MODE_W-1:0] MODE_ECHO     = 3'd4;
    localparam logic [MODE_W-1:0] MODE_MUTE     = 3'd5;
    localparam logic [MODE_W-1:0] MODE_FADE_IN2 = 3'd6;
    localparam logic [MODE_W-1:0] MODE_HALF2    = 3'd7;

    // Register reset values.
    localparam logic [CLIP_W-1:0]   CLIP_RESET  = 24'd44100;
    localparam logic [DELAY_AW-1:0] DELAY_RESET = 13'd7350;
    localparam logic [GAIN_W-1:0]   GAIN_RESET  = 15'd31130;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MEM,
        S_EFF,
        S_ECHO,
        S_FADE,
        S_DIV,
        S_DONE
    } t_state;

    // Request to the ramp unit: result = sign * (mag * num / den), truncated.
    typedef struct packed {
        logic              start;
        logic              neg;
        logic [MAG_W-1:0]  mag;
        logic [PLEN_W-1:0] num;
        logic [PLEN_W-1:0] den;
    } t_div_req;

    typedef struct packed {
        logic                       done;
        logic signed [SAMPLE_W-1:0] result;
    } t_div_rsp;

    function automatic logic signed [SAMPLE_W-1:0] f_sat(input logic signed [WIDE_W-1:0] v);
        logic signed [WIDE_W-1:0] hi;
        logic signed [WIDE_W-1:0] lo;
        hi = WIDE_W'(signed'({1'b0, {(SAMPLE_W-1){1'b1}}}));
        lo = WIDE_W'(signed'({1'b1, {(SAMPLE_W-1){1'b0}}}));
        if (v > hi) begin
            f_sat = hi[SAMPLE_W-1:0];
        end else if (v < lo) begin
            f_sat = lo[SAMPLE_W-1:0];
        end else begin
            f_sat = v[SAMPLE_W-1:0];
        end
    endfunction

endpackage

### rtl/core/audio_gain_fade_echo_effect.sv
// Top level of the audio gain, fade and echo effect.
// Depends on agfe_pkg, agfe_ram (delay line) and agfe_ramp_div (fade ramps).
//
// Usage: configure the five registers through the write port (index 0 effect
// mode, 1 fade-out enable, 2 clip length, 3 echo delay, 4 echo gain) while the
// block is idle. Source samples then enter on the slave stream, one item per
// handshake, with tuser high on the first sample of each clip; that flag
// restarts the sample index and empties the delay line. In echo mode the host
// follows the clip with echo_delay zero samples. Each input item yields exactly
// one output item on the master stream, with tlast marking the final sample of
// the processed length.
// An accepted item passes through S_MEM, S_EFF, S_ECHO (echo mode only) and
// S_FADE to S_DONE; each active ramp (fade-in, fade-out) adds a pass through
// S_DIV for the bit-serial divider. The block returns to idle before each item
// is accepted, so it takes a new item only once the last one has left S_DONE;
// the divider sets the rate whenever a ramp is active.
// The delay line is a single 8192-entry RAM, read and written once per item; a
// fill count stands in for its clearing, so no clearing pass follows reset.
// Reset returns each config register to its documented value, the stream empty.
// The finished item waits in the output register while the receiver stalls; the
// next input item is accepted and processed meanwhile, and holds only at the end
// until the output register is free.
module audio_gain_fade_echo_effect (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // Configuration write port.
    input  logic                             i_cfg_we,
    input  logic [agfe_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [agfe_pkg::CFG_W-1:0]       i_cfg_data,
    // Input stream.
    input  logic                             i_s_tvalid,
    output logic                             o_s_tready,
    input  logic [agfe_pkg::SAMPLE_W-1:0]    i_s_tdata,   // [15:0] in_sample
    input  logic                             i_s_tuser,   // [0] clip_start
    // Output stream.
    output logic                             o_m_tvalid,
    input  logic                             i_m_tready,
    output logic [agfe_pkg::SAMPLE_W-1:0]    o_m_tdata,   // [15:0] out_sample
    output logic                             o_m_tlast    // last_sample
);

    localparam int SW = agfe_pkg::SAMPLE_W;
    localparam int WW = agfe_pkg::WIDE_W;

    // Configuration registers.
    logic [agfe_pkg::MODE_W-1:0]   r_mode;
    logic                          r_fade_en;
    logic [agfe_pkg::CLIP_W-1:0]   r_clip;
    logic [agfe_pkg::DELAY_AW-1:0] r_delay;
    logic [agfe_pkg::GAIN_W-1:0]   r_gain;

    // Control and sample state.
    agfe_pkg::t_state              r_state, n_state;
    logic [agfe_pkg::INDEX_W-1:0]  r_idx;
    logic [agfe_pkg::DELAY_AW-1:0] r_ptr;
    logic [agfe_pkg::FILL_W-1:0]   r_fill;
    logic                          r_out_valid;
    logic [SW-1:0]                 r_out_data;
    logic                          r_out_last;

    // Per-item payload.
    logic signed [SW-1:0]          r_x;
    logic                          r_start;
    logic [agfe_pkg::INDEX_W-1:0]  r_n;
    logic [agfe_pkg::PLEN_W-1:0]   r_plen;
    logic                          r_dzero;
    logic                          r_evalid;
    logic signed [2*SW-1:0]        r_prod;
    logic signed [SW-1:0]          r_y, n_y;
    logic                          r_fin, n_fin;

    // Combinational signals.
    logic                          in_acc;
    logic                          load_out;
    logic [agfe_pkg::INDEX_W-1:0]  n_eff;
    logic [agfe_pkg::DELAY_AW-1:0] ptr_eff;
    logic [agfe_pkg::FILL_W-1:0]   fill_new;
    logic [agfe_pkg::DELAY_AW-1:0] raddr;
    logic [SW-1:0]                 rdata;
    logic signed [SW-1:0]          echo_src;
    logic [agfe_pkg::PLEN_W-1:0]   fade_len;
    logic [agfe_pkg::PLEN_W+1:0]   plen_x3;
    logic [agfe_pkg::PLEN_W-1:0]   fade_from;
    logic                          fade_out_hit;
    logic [agfe_pkg::CLIP_W-3:0]   fade_to;
    logic                          fade_in_hit;
    logic signed [WW-1:0]          boost;
    logic signed [WW-1:0]          echo_sum;
    logic                          is_last;
    agfe_pkg::t_div_req            div_req;
    agfe_pkg::t_div_rsp            div_rsp;

    // ------------------------------------------------------------------
    // Configuration port.
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode    <= agfe_pkg::MODE_NONE;
            r_fade_en <= 1'b0;
            r_clip    <= agfe_pkg::CLIP_RESET;
            r_delay   <= agfe_pkg::DELAY_RESET;
            r_gain    <= agfe_pkg::GAIN_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                agfe_pkg::REG_EFFECT_MODE: r_mode    <= i_cfg_data[agfe_pkg::MODE_W-1:0];
                agfe_pkg::REG_FADE_OUT_EN: r_fade_en <= i_cfg_data[0];
                agfe_pkg::REG_CLIP_LENGTH: r_clip    <= i_cfg_data[agfe_pkg::CLIP_W-1:0];
                agfe_pkg::REG_ECHO_DELAY:  r_delay   <= i_cfg_data[agfe_pkg::DELAY_AW-1:0];
                agfe_pkg::REG_ECHO_GAIN:   r_gain    <= i_cfg_data[agfe_pkg::GAIN_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Delay line. Every sample is written at the pointer; the echo tap is
    // read D slots back in the same cycle. The fill count tells how many
    // slots hold samples written since the last clear: a tap further back
    // than that reads as silence. A zero delay taps the sample itself.
    // ------------------------------------------------------------------
    assign n_eff    = r_start ? '0 : r_idx;
    assign ptr_eff  = r_start ? '0 : r_ptr;
    assign fill_new = r_start ? agfe_pkg::FILL_W'(1)
                    : (r_fill == agfe_pkg::FILL_W'(agfe_pkg::MAX_DELAY)) ? r_fill
                    : r_fill + 1'b1;
    assign raddr    = ptr_eff - r_delay;

    agfe_ram #(
        .WIDTH (agfe_pkg::SAMPLE_W),
        .DEPTH (agfe_pkg::MAX_DELAY)
    ) u_delay_ram (
        .i_clk   (i_clk),
        .i_we    (r_state == agfe_pkg::S_MEM),
        .i_waddr (ptr_eff),
        .i_wdata (r_x),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    agfe_ramp_div u_ramp_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    // ------------------------------------------------------------------
    // Effect arithmetic.
    // ------------------------------------------------------------------
    assign echo_src = r_dzero ? r_x : (r_evalid ? signed'(rdata) : '0);

    // Gain 1.25 is x * 5 / 4, floored.
    assign boost    = (WW'(r_x) * WW'(5)) >>> 2;
    assign echo_sum = WW'(r_x) + WW'(r_prod >>> 15);

    assign fade_to     = r_clip[agfe_pkg::CLIP_W-1:2];
    assign fade_in_hit = (r_n < agfe_pkg::INDEX_W'(fade_to));

    assign plen_x3      = {2'b00, r_plen} + {1'b0, r_plen, 1'b0};
    assign fade_from    = plen_x3[agfe_pkg::PLEN_W+1:2];
    assign fade_len     = r_plen - fade_from;
    assign fade_out_hit = r_fade_en && (r_n < r_plen) && (r_n >= fade_from);

    assign is_last = (r_plen != '0) && (r_n == r_plen - 1'b1);

    assign in_acc     = i_s_tvalid && o_s_tready;
    assign o_s_tready = (r_state == agfe_pkg::S_IDLE);
    assign load_out   = (r_state == agfe_pkg::S_DONE) && (!r_out_valid || i_m_tready);

    // ------------------------------------------------------------------
    // Sequencer.
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= agfe_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        n_y     = r_y;
        n_fin   = r_fin;
        div_req = '0;
        case (r_state)
            agfe_pkg::S_IDLE: begin
                if (in_acc) begin
                    n_state = agfe_pkg::S_MEM;
                end
            end
            agfe_pkg::S_MEM: begin
                n_state = agfe_pkg::S_EFF;
            end
            agfe_pkg::S_EFF: begin
                n_state = agfe_pkg::S_FADE;
                case (r_mode)
                    agfe_pkg::MODE_FADE_IN, agfe_pkg::MODE_FADE_IN2: begin
                        n_y = r_x;
                        if (fade_in_hit) begin
                            div_req.start = 1'b1;
                            div_req.neg   = r_x[SW-1];
                            div_req.mag   = r_x[SW-1] ? agfe_pkg::MAG_W'(-WW'(r_x))
                                                      : agfe_pkg::MAG_W'(WW'(r_x));
                            div_req.num   = r_n;
                            div_req.den   = agfe_pkg::PLEN_W'(fade_to);
                            n_fin         = 1'b1;
                            n_state       = agfe_pkg::S_DIV;
                        end
                    end
                    agfe_pkg::MODE_HALF, agfe_pkg::MODE_HALF2: n_y = r_x >>> 1;
                    agfe_pkg::MODE_BOOST: n_y = agfe_pkg::f_sat(boost);
                    agfe_pkg::MODE_ECHO:  n_state = agfe_pkg::S_ECHO;
                    agfe_pkg::MODE_MUTE:  n_y = '0;
                    agfe_pkg::MODE_NONE:  n_y = r_x;
                    default:              n_y = r_x;
                endcase
            end
            agfe_pkg::S_ECHO: begin
                n_y     = agfe_pkg::f_sat(echo_sum);
                n_state = agfe_pkg::S_FADE;
            end
            agfe_pkg::S_FADE: begin
                if (fade_out_hit) begin
                    div_req.start = 1'b1;
                    div_req.neg   = r_y[SW-1];
                    div_req.mag   = r_y[SW-1] ? agfe_pkg::MAG_W'(-WW'(r_y))
                                              : agfe_pkg::MAG_W'(WW'(r_y));
                    div_req.num   = agfe_pkg::PLEN_W'(r_plen - r_n);
                    div_req.den   = fade_len;
                    n_fin         = 1'b0;
                    n_state       = agfe_pkg::S_DIV;
                end else begin
                    n_state = agfe_pkg::S_DONE;
                end
            end
            agfe_pkg::S_DIV: begin
                if (div_rsp.done) begin
                    n_y     = div_rsp.result;
                    n_state = r_fin ? agfe_pkg::S_FADE : agfe_pkg::S_DONE;
                end
            end
            agfe_pkg::S_DONE: begin
                if (load_out) begin
                    n_state = agfe_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = agfe_pkg::S_IDLE;
            end
        endcase
    end

    // Sample index, delay pointer and fill count advance once per item.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx  <= '0;
            r_ptr  <= '0;
            r_fill <= '0;
        end else if (r_state == agfe_pkg::S_MEM) begin
            r_idx  <= (&n_eff) ? n_eff : n_eff + 1'b1;
            r_ptr  <= ptr_eff + 1'b1;
            r_fill <= fill_new;
        end
    end

    // Per-item payload registers.
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_x     <= signed'(i_s_tdata);
            r_start <= i_s_tuser;
        end
        if (r_state == agfe_pkg::S_MEM) begin
            r_n      <= n_eff;
            r_plen   <= {1'b0, r_clip}
                      + ((r_mode == agfe_pkg::MODE_ECHO) ? agfe_pkg::PLEN_W'(r_delay) : '0);
            r_dzero  <= (r_delay == '0);
            r_evalid <= ({1'b0, r_delay} < fill_new);
        end
        if (r_state == agfe_pkg::S_EFF) begin
            r_prod <= echo_src * signed'({1'b0, r_gain});
        end
        r_y   <= n_y;
        r_fin <= n_fin;
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_out_data <= r_y;
            r_out_last <= is_last;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;
    assign o_m_tlast  = r_out_last;

endmodule

### rtl/core/agfe_ram.sv
// Generic single-clock RAM: one write port and one read port with registered read data.
// Stand-alone; no package dependency.
module agfe_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 8192
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/core/agfe_ramp_div.sv
// Ramp unit: registered multiply then a restoring divider, one quotient bit per cycle.
// Depends on agfe_pkg for widths, request and response types and saturation.
module agfe_ramp_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  agfe_pkg::t_div_req i_req,
    output agfe_pkg::t_div_rsp o_rsp
);

    logic                          r_busy;
    logic                          r_done;
    logic [agfe_pkg::STEP_W-1:0]   r_step;
    logic [agfe_pkg::PROD_W-1:0]   r_rem;
    logic [agfe_pkg::PROD_W-1:0]   r_dsr;
    logic [agfe_pkg::QUOT_W-1:0]   r_q;
    logic                          r_neg;
    logic                          ge;
    logic signed [agfe_pkg::WIDE_W-1:0] signed_q;

    assign ge = (r_rem >= r_dsr);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start && !r_busy) begin
                r_busy <= 1'b1;
                r_step <= agfe_pkg::STEP_W'(agfe_pkg::QUOT_W);
            end else if (r_busy) begin
                r_step <= r_step - 1'b1;
                if (r_step == agfe_pkg::STEP_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // The quotient never exceeds the magnitude, so the divisor starts
    // shifted by one less than the quotient width.
    always_ff @(posedge i_clk) begin
        if (i_req.start && !r_busy) begin
            r_rem <= agfe_pkg::PROD_W'(i_req.mag * i_req.num);
            r_dsr <= agfe_pkg::PROD_W'({i_req.den, {(agfe_pkg::QUOT_W-1){1'b0}}});
            r_q   <= '0;
            r_neg <= i_req.neg;
        end else if (r_busy) begin
            if (ge) begin
                r_rem <= r_rem - r_dsr;
            end
            r_q   <= {r_q[agfe_pkg::QUOT_W-2:0], ge};
            r_dsr <= r_dsr >> 1;
        end
    end

    always_comb begin
        signed_q = agfe_pkg::WIDE_W'(signed'({1'b0, r_q}));
        if (r_neg) begin
            signed_q = -signed_q;
        end
        o_rsp.done   = r_done;
        o_rsp.result = agfe_pkg::f_sat(signed_q);
    end

endmodule
